>>> design/modbus_rtu_request_framer_top_macros.svh
// Assertion macros for the Modbus RTU request framer.
`ifndef MODBUS_RTU_REQUEST_FRAMER_TOP_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MRF_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer check failed");

// next-cycle implication, disabled during reset
`define MRF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

>>> design/mrf_pkg.sv
// Shared types, constants and CRC function for the Modbus RTU request framer.
package mrf_pkg;

  localparam int MAX_WRITE_REGS = 123;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // job queue between front and back
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = 2;
  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  // configuration register indexes
  localparam logic [2:0] REG_CODE_READ         = 3'd0;
  localparam logic [2:0] REG_CODE_SINGLE_WRITE = 3'd1;
  localparam logic [2:0] REG_CODE_SINGLE_COIL  = 3'd2;
  localparam logic [2:0] REG_CODE_MULTI_WRITE  = 3'd3;
  localparam logic [2:0] REG_CODE_MULTI_COIL   = 3'd4;

  // job kinds
  localparam logic [2:0] KIND_BAD      = 3'd0;  // refused header: 8 zero bytes
  localparam logic [2:0] KIND_FULL     = 3'd1;  // 6 header bytes + crc
  localparam logic [2:0] KIND_OPEN     = 3'd2;  // 7 header bytes, payload follows
  localparam logic [2:0] KIND_ZERO     = 3'd3;  // 7 header bytes + crc
  localparam logic [2:0] KIND_DATA     = 3'd4;  // one payload byte
  localparam logic [2:0] KIND_DATA_END = 3'd5;  // last payload byte + crc

  typedef struct packed {
    logic [7:0] code_read;
    logic [7:0] code_single_write;
    logic [7:0] code_single_coil;
    logic [7:0] code_multi_write;
    logic [7:0] code_multi_coil;
  } codes_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  dev_addr;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [15:0] reg_word;
    logic [7:0]  data_byte;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int n = 0; n < 8; n++) begin
      if (r[0]) r = (r >> 1) ^ CRC_POLY;
      else      r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic is_header_kind(input logic [2:0] kind);
    return (kind == KIND_BAD) || (kind == KIND_FULL) ||
           (kind == KIND_OPEN) || (kind == KIND_ZERO);
  endfunction

endpackage

>>> design/mrf_front.sv
// Front end: classifies header and payload items, tracks the open frame, queues jobs.
module mrf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           cmd,
  input  logic [7:0]     dev_addr,
  input  logic [7:0]     func_code,
  input  logic [15:0]    reg_addr,
  input  logic [15:0]    reg_word,
  input  logic [7:0]     data_byte,
  input  mrf_pkg::codes_t codes,
  output mrf_pkg::job_t   job,
  output logic           job_valid,
  input  logic           job_pop
);
  import mrf_pkg::*;

  logic             in_payload, in_payload_next;
  logic [7:0]       payload_left, payload_left_next;
  job_t             queue [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr, rd_ptr;
  logic [JQ_AW:0]   count;

  logic       accept, job_push;
  logic       single, multi, rd_code, refused;
  logic [7:0] byte_cnt;
  job_t       new_job;

  assign accept = push && !full;

  always_comb begin
    single   = (func_code == codes.code_single_write) || (func_code == codes.code_single_coil);
    multi    = !single &&
               ((func_code == codes.code_multi_write) || (func_code == codes.code_multi_coil));
    rd_code  = !single && !multi && (func_code == codes.code_read);
    refused  = (!single && !multi && !rd_code) ||
               (multi && (reg_word > 16'(MAX_WRITE_REGS)));
    byte_cnt = {reg_word[6:0], 1'b0};

    new_job.kind      = KIND_BAD;
    new_job.dev_addr  = dev_addr;
    new_job.func_code = func_code;
    new_job.reg_addr  = reg_addr;
    new_job.reg_word  = reg_word;
    new_job.data_byte = data_byte;
    job_push          = 1'b0;
    in_payload_next   = in_payload;
    payload_left_next = payload_left;

    if (accept) begin
      if (!cmd) begin
        // a header drops any open frame
        job_push          = 1'b1;
        in_payload_next   = 1'b0;
        payload_left_next = 8'd0;
        if (refused) begin
          new_job.kind = KIND_BAD;
        end else if (multi) begin
          if (byte_cnt == 8'd0) begin
            new_job.kind = KIND_ZERO;
          end else begin
            new_job.kind      = KIND_OPEN;
            in_payload_next   = 1'b1;
            payload_left_next = byte_cnt;
          end
        end else begin
          new_job.kind = KIND_FULL;
        end
      end else if (in_payload) begin
        job_push          = 1'b1;
        payload_left_next = payload_left - 8'd1;
        if (payload_left == 8'd1) begin
          new_job.kind    = KIND_DATA_END;
          in_payload_next = 1'b0;
        end else begin
          new_job.kind = KIND_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      payload_left <= 8'd0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      in_payload   <= in_payload_next;
      payload_left <= payload_left_next;
      if (job_push) wr_ptr <= wr_ptr + 1'b1;
      if (job_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({job_push, job_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) queue[wr_ptr] <= new_job;
  end

  assign full      = (count == (JQ_AW+1)'(JQ_DEPTH));
  assign job_valid = (count != '0);
  assign job        = queue[rd_ptr];

endmodule

>>> design/mrf_back.sv
// Back end: serializes queued jobs into frame bytes with the running CRC, plus result queue.
module mrf_back (
  input  logic          clk,
  input  logic          rst,
  input  mrf_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    frame_byte,
  output logic          last_byte,
  output logic          bad_request
);
  import mrf_pkg::*;

  logic [3:0]  idx;
  logic [15:0] crc, crc_next, crc_in;

  logic [7:0]       oq_byte [OQ_DEPTH];
  logic             oq_last [OQ_DEPTH];
  logic             oq_bad  [OQ_DEPTH];
  logic [OQ_AW-1:0] owr_ptr, ord_ptr;
  logic [OQ_AW:0]   ocount;

  logic       emit, oq_pop, has_crc, is_bad, at_end;
  logic [3:0] n_data, len;
  logic [7:0] data_val, out_val;
  logic       out_last;

  assign is_bad = (job.kind == KIND_BAD);
  assign oq_pop = pop && !empty;
  assign emit   = job_valid && (ocount != (OQ_AW+1)'(OQ_DEPTH));

  always_comb begin
    case (job.kind)
      KIND_BAD:      begin n_data = 4'd8; has_crc = 1'b0; end
      KIND_FULL:     begin n_data = 4'd6; has_crc = 1'b1; end
      KIND_OPEN:     begin n_data = 4'd7; has_crc = 1'b0; end
      KIND_ZERO:     begin n_data = 4'd7; has_crc = 1'b1; end
      KIND_DATA:     begin n_data = 4'd1; has_crc = 1'b0; end
      KIND_DATA_END: begin n_data = 4'd1; has_crc = 1'b1; end
      default:       begin n_data = 4'd1; has_crc = 1'b0; end
    endcase
    len    = has_crc ? n_data + 4'd2 : n_data;
    at_end = (idx == len - 4'd1);

    if (job.kind == KIND_DATA || job.kind == KIND_DATA_END) begin
      data_val = job.data_byte;
    end else begin
      case (idx)
        4'd0:    data_val = job.dev_addr;
        4'd1:    data_val = job.func_code;
        4'd2:    data_val = job.reg_addr[15:8];
        4'd3:    data_val = job.reg_addr[7:0];
        4'd4:    data_val = job.reg_word[15:8];
        4'd5:    data_val = job.reg_word[7:0];
        4'd6:    data_val = {job.reg_word[6:0], 1'b0};  // byte count
        default: data_val = 8'd0;
      endcase
    end

    // a header restarts the CRC, dropping any unfinished frame
    crc_in = (is_header_kind(job.kind) && idx == 4'd0) ? CRC_INIT : crc;

    if (is_bad)               out_val = 8'd0;
    else if (idx < n_data)    out_val = data_val;
    else if (idx == n_data)   out_val = crc[7:0];
    else                      out_val = crc[15:8];

    out_last = is_bad ? (idx == 4'd7) : (has_crc && at_end);

    if (is_bad || (has_crc && at_end)) crc_next = CRC_INIT;
    else if (idx < n_data)             crc_next = crc_byte(crc_in, data_val);
    else                               crc_next = crc;
  end

  assign job_pop = emit && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= 4'd0;
      crc     <= CRC_INIT;
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (emit) begin
        idx <= at_end ? 4'd0 : idx + 4'd1;
        crc <= crc_next;
        owr_ptr <= owr_ptr + 1'b1;
      end
      if (oq_pop) ord_ptr <= ord_ptr + 1'b1;
      case ({emit, oq_pop})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_byte[owr_ptr] <= out_val;
      oq_last[owr_ptr] <= out_last;
      oq_bad[owr_ptr]  <= is_bad;
    end
  end

  assign empty       = (ocount == '0);
  assign frame_byte  = oq_byte[ord_ptr];
  assign last_byte   = oq_last[ord_ptr];
  assign bad_request = oq_bad[ord_ptr];

endmodule

>>> design/modbus_rtu_request_framer_top.sv
// Top level of the Modbus RTU request framer: config registers, front and back ends.
//
// Input channel: push/full. An item is taken at a clock edge with push high and
// full low. A header item (cmd 0) opens a frame; payload items (cmd 1) carry the
// data bytes of a multiple write and are dropped when no frame is open.
// Result channel: empty/pop. frame_byte, last_byte and bad_request show the
// oldest byte while empty is low; pop takes it.
// Config: wr_en/wr_index/wr_data write one function code register per edge, the
// one picked by wr_index; write only while no item is in flight.
// The first byte of an item is written through the job queue and then the result queue,
// both registered, before it shows on the result ports and can be popped.
// The byte serializer emits one byte per cycle while the result queue has room, so
// a payload item gives one byte (three for the last one, which carries the CRC), and a
// header item gives 7 to 9 bytes. A four-entry job queue between the
// classifier and the serializer lets headers be taken while the serializer works.
// Reset (rst, synchronous) empties both queues, closes any open frame, restores
// the function codes and sets the CRC to 0xFFFF.
// When the receiver stops popping, the four-entry result queue fills, the
// serializer holds, the job queue fills and full rises; nothing is lost.
module modbus_rtu_request_framer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  dev_addr,
  input  logic [7:0]  func_code,
  input  logic [15:0] reg_addr,
  input  logic [15:0] reg_word,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic        last_byte,
  output logic        bad_request,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [7:0]  wr_data
);
  import mrf_pkg::*;

  `include "modbus_rtu_request_framer_top_macros.svh"

  codes_t codes;
  job_t   job;
  logic   job_valid, job_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.code_read         <= 8'd3;
      codes.code_single_write <= 8'd6;
      codes.code_single_coil  <= 8'd5;
      codes.code_multi_write  <= 8'd16;
      codes.code_multi_coil   <= 8'd15;
    end else if (wr_en) begin
      case (wr_index)
        REG_CODE_READ:         codes.code_read         <= wr_data;
        REG_CODE_SINGLE_WRITE: codes.code_single_write <= wr_data;
        REG_CODE_SINGLE_COIL:  codes.code_single_coil  <= wr_data;
        REG_CODE_MULTI_WRITE:  codes.code_multi_write  <= wr_data;
        REG_CODE_MULTI_COIL:   codes.code_multi_coil   <= wr_data;
        default:               codes <= codes;
      endcase
    end
  end

  mrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .dev_addr  (dev_addr),
    .func_code (func_code),
    .reg_addr  (reg_addr),
    .reg_word  (reg_word),
    .data_byte (data_byte),
    .codes     (codes),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop)
  );

  mrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (job),
    .job_valid   (job_valid),
    .job_pop     (job_pop),
    .empty       (empty),
    .pop         (pop),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte),
    .bad_request (bad_request)
  );

  // a refused frame is all zeros
  `MRF_CHECK_NOW(a_bad_is_zero, (!empty && bad_request), (frame_byte == 8'd0))
  // every accepted header leaves a job for the serializer
  `MRF_CHECK_NEXT(a_header_queued, (push && !full && !cmd), job_valid)
  // a job stays queued until the serializer finishes it
  `MRF_CHECK_NEXT(a_job_held, (job_valid && !job_pop), job_valid)
  // the serializer only finishes a job it has
  `MRF_CHECK_NOW(a_pop_has_job, job_pop, job_valid)

endmodule

>>> tb/tb_modbus_rtu_request_framer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU request framer top level.
module tb_modbus_rtu_request_framer_top;
  import mrf_pkg::*;

  // function codes after reset
  localparam logic [7:0] FC_READ   = 8'd3;
  localparam logic [7:0] FC_SWRITE = 8'd6;
  localparam logic [7:0] FC_SCOIL  = 8'd5;
  localparam logic [7:0] FC_MWRITE = 8'd16;
  localparam logic [7:0] FC_MCOIL  = 8'd15;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  dev;
    logic [7:0]  fc;
    logic [15:0] ra;
    logic [15:0] wd;
    logic [7:0]  db;
  } req_item_t;

  typedef struct packed {
    logic [7:0] fb;
    logic       lb;
    logic       bad;
  } frame_out_t;

  typedef enum logic [1:0] {BY_MODEL, BY_REFUSAL, BY_SILENCE} exp_src_e;

  typedef struct packed {
    req_item_t it;
    exp_src_e  src;
  } intro_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd = 1'b0;
  logic [7:0]  dev_addr = 8'h00;
  logic [7:0]  func_code = 8'h00;
  logic [15:0] reg_addr = 16'h0000;
  logic [15:0] reg_word = 16'h0000;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        bad_request;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = REG_CODE_READ;
  logic [7:0]  wr_data = 8'h00;

  modbus_rtu_request_framer_top u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .cmd(cmd), .dev_addr(dev_addr), .func_code(func_code),
    .reg_addr(reg_addr), .reg_word(reg_word), .data_byte(data_byte),
    .empty(empty), .pop(pop),
    .frame_byte(frame_byte), .last_byte(last_byte), .bad_request(bad_request),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // framer state as the testbench sees it
  codes_t      code_set;
  logic [15:0] crc_run;
  logic [7:0]  payload_cnt;
  logic        frame_open;

  frame_out_t  model_bytes[$];    // bytes caused by the latest item
  frame_out_t  pending_bytes[$];  // bytes still owed by the framer
  int          err_count = 0;
  bit          quiet = 1'b0;
  int          pop_hold = 0;

  intro_row_t intro_rows [24] = '{
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'hFF}, BY_SILENCE},
    '{'{1'b0, 8'h01, FC_READ,   16'h0000, 16'h000A, 8'h00}, BY_MODEL},
    '{'{1'b0, 8'hFF, FC_READ,   16'hFFFF, 16'hFFFF, 8'hFF}, BY_MODEL},
    '{'{1'b0, 8'h00, FC_SWRITE, 16'h1234, 16'hABCD, 8'h00}, BY_MODEL},
    '{'{1'b0, 8'h11, FC_SCOIL,  16'h00AC, 16'hFF00, 8'h00}, BY_MODEL},
    '{'{1'b0, 8'h01, 8'h00,     16'h0000, 16'h0001, 8'h00}, BY_REFUSAL},
    '{'{1'b0, 8'h01, 8'hFF,     16'h0000, 16'h0001, 8'h00}, BY_REFUSAL},
    '{'{1'b0, 8'h0A, FC_MWRITE, 16'h0001, 16'h0000, 8'h00}, BY_MODEL},
    '{'{1'b0, 8'h0A, FC_MCOIL,  16'h0001, 16'd124,  8'h00}, BY_REFUSAL},
    '{'{1'b0, 8'h0A, FC_MWRITE, 16'h0001, 16'hFFFF, 8'h00}, BY_REFUSAL},
    '{'{1'b0, 8'h22, FC_MWRITE, 16'h0100, 16'h0002, 8'h00}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'h00}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'hFF}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'h55}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'hAA}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'h33}, BY_SILENCE},
    '{'{1'b0, 8'h7F, FC_MCOIL,  16'h8000, 16'd123,  8'h00}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'h01}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'h80}, BY_MODEL},
    '{'{1'b0, 8'h05, FC_READ,   16'h0010, 16'h0004, 8'h00}, BY_MODEL},
    '{'{1'b0, 8'h06, FC_MWRITE, 16'h0020, 16'h0001, 8'h00}, BY_MODEL},
    '{'{1'b1, 8'h00, 8'h00,     16'h0000, 16'h0000, 8'h5A}, BY_MODEL},
    '{'{1'b0, 8'h07, FC_MCOIL,  16'h0030, 16'h0001, 8'h00}, BY_MODEL},
    '{'{1'b0, 8'h08, 8'h42,     16'h0040, 16'h0001, 8'h00}, BY_REFUSAL}
  };

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int n = 0; n < 8; n++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic note_byte(input logic [7:0] b, input logic lb, input logic bad);
    model_bytes.push_back('{b, lb, bad});
  endtask

  task automatic emit_data(input logic [7:0] b);
    crc_run = crc_step(crc_run, b);
    note_byte(b, 1'b0, 1'b0);
  endtask

  task automatic emit_crc();
    note_byte(crc_run[7:0], 1'b0, 1'b0);
    note_byte(crc_run[15:8], 1'b1, 1'b0);
    crc_run = CRC_INIT;
  endtask

  // works out the frame bytes one item causes and advances the framer state
  task automatic frame_predict(input req_item_t it);
    logic       single;
    logic       multi;
    logic       rd;
    logic [7:0] cnt;
    model_bytes.delete();
    if (it.cmd) begin
      if (frame_open) begin
        emit_data(it.db);
        payload_cnt = payload_cnt - 8'd1;
        if (payload_cnt == 8'd0) begin
          frame_open = 1'b0;
          emit_crc();
        end
      end
    end else begin
      // a header drops whatever frame was open
      frame_open  = 1'b0;
      payload_cnt = 8'd0;
      crc_run     = CRC_INIT;
      single = (it.fc == code_set.code_single_write) || (it.fc == code_set.code_single_coil);
      multi  = !single && ((it.fc == code_set.code_multi_write) ||
                           (it.fc == code_set.code_multi_coil));
      rd     = !single && !multi && (it.fc == code_set.code_read);
      if ((!single && !multi && !rd) || (multi && it.wd > MAX_WRITE_REGS)) begin
        for (int i = 0; i < 8; i++)
          note_byte(8'h00, i == 7, 1'b1);
      end else begin
        emit_data(it.dev);
        emit_data(it.fc);
        emit_data(it.ra[15:8]);
        emit_data(it.ra[7:0]);
        emit_data(it.wd[15:8]);
        emit_data(it.wd[7:0]);
        if (multi) begin
          cnt = {it.wd[6:0], 1'b0};
          emit_data(cnt);
          if (cnt == 8'd0) begin
            emit_crc();
          end else begin
            payload_cnt = cnt;
            frame_open  = 1'b1;
          end
        end else begin
          emit_crc();
        end
      end
    end
  endtask

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_result();
    frame_out_t want;
    if (pending_bytes.size() == 0) begin
      report($sformatf("byte %h with nothing expected", frame_byte));
    end else begin
      want = pending_bytes.pop_front();
      if (frame_byte !== want.fb)
        report($sformatf("frame_byte %h, expected %h", frame_byte, want.fb));
      if (last_byte !== want.lb)
        report($sformatf("last_byte %b, expected %b", last_byte, want.lb));
      if (bad_request !== want.bad)
        report($sformatf("bad_request %b, expected %b", bad_request, want.bad));
    end
  endtask

  // result side: check accepted bytes, stall pop in short bursts
  always @(posedge clk) begin
    if (pop && !empty)
      check_result();
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop_hold = pop_hold - 1;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      pop_hold = $urandom_range(0, 3);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(input req_item_t it, input exp_src_e src);
    push      <= 1'b1;
    cmd       <= it.cmd;
    dev_addr  <= it.dev;
    func_code <= it.fc;
    reg_addr  <= it.ra;
    reg_word  <= it.wd;
    data_byte <= it.db;
    @(posedge clk);
    while (full) @(posedge clk);
    frame_predict(it);
    case (src)
      BY_MODEL: begin
        foreach (model_bytes[i]) pending_bytes.push_back(model_bytes[i]);
      end
      BY_REFUSAL: begin
        for (int i = 0; i < 8; i++) pending_bytes.push_back('{8'h00, i == 7, 1'b1});
      end
      default: ;
    endcase
  endtask

  task automatic send_paced(input req_item_t it, input exp_src_e src);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    send_item(it, src);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    // a dropped payload item may still be in the pipe
    repeat (12) @(posedge clk);
  endtask

  task automatic code_write(input logic [2:0] idx, input logic [7:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(posedge clk);
    case (idx)
      REG_CODE_READ:         code_set.code_read = v;
      REG_CODE_SINGLE_WRITE: code_set.code_single_write = v;
      REG_CODE_SINGLE_COIL:  code_set.code_single_coil = v;
      REG_CODE_MULTI_WRITE:  code_set.code_multi_write = v;
      REG_CODE_MULTI_COIL:   code_set.code_multi_coil = v;
      default: ;
    endcase
  endtask

  task automatic write_codes(input codes_t c);
    code_write(REG_CODE_READ, c.code_read);
    code_write(REG_CODE_SINGLE_WRITE, c.code_single_write);
    code_write(REG_CODE_SINGLE_COIL, c.code_single_coil);
    code_write(REG_CODE_MULTI_WRITE, c.code_multi_write);
    code_write(REG_CODE_MULTI_COIL, c.code_multi_coil);
    wr_en <= 1'b0;
  endtask

  // mostly well-formed frames with their payload, plus refusals and strays
  task automatic random_frames(input int n_items);
    req_item_t it;
    int        sent;
    int        pick;
    int        stop_at;
    sent = 0;
    while (sent < n_items) begin
      it.cmd = 1'b0;
      it.dev = 8'($urandom);
      it.fc  = 8'($urandom);
      it.ra  = 16'($urandom);
      it.wd  = 16'($urandom);
      it.db  = 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        it.fc = code_set.code_read;
      end else if (pick < 6) begin
        it.fc = code_set.code_single_write;
      end else if (pick < 8) begin
        it.fc = code_set.code_single_coil;
      end else if (pick < 14) begin
        it.fc = pick[0] ? code_set.code_multi_write : code_set.code_multi_coil;
        it.wd = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, MAX_WRITE_REGS))
                                            : 16'($urandom_range(0, 5));
      end else if (pick < 16) begin
        it.fc = pick[0] ? code_set.code_multi_write : code_set.code_multi_coil;
        it.wd = 16'($urandom_range(MAX_WRITE_REGS + 1, 65535));
      end else if (pick >= 18) begin
        it.cmd = 1'b1;
      end
      // a payload item with no open frame is ignored and does not count
      if (!it.cmd || frame_open)
        sent++;
      send_paced(it, BY_MODEL);
      if (!it.cmd && frame_open) begin
        stop_at = int'(payload_cnt);
        // long frames and a few short ones get cut off by the next header
        if (stop_at > 12 || $urandom_range(0, 7) == 0)
          stop_at = $urandom_range(1, (stop_at > 8) ? 8 : stop_at);
        repeat (stop_at) begin
          it.cmd = 1'b1;
          it.dev = 8'($urandom);
          it.fc  = 8'($urandom);
          it.ra  = 16'($urandom);
          it.wd  = 16'($urandom);
          it.db  = 8'($urandom);
          send_paced(it, BY_MODEL);
          sent++;
        end
      end
    end
  endtask

  initial begin
    code_set    = '{FC_READ, FC_SWRITE, FC_SCOIL, FC_MWRITE, FC_MCOIL};
    crc_run     = CRC_INIT;
    payload_cnt = 8'd0;
    frame_open  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (intro_rows[i])
      send_paced(intro_rows[i].it, intro_rows[i].src);
    random_frames(30);

    drain();
    write_codes('{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80});
    random_frames(25);

    // overlapping codes: multi beats read, and both single codes share one value
    drain();
    write_codes('{8'h10, 8'h05, 8'h05, 8'h10, 8'h03});
    random_frames(25);

    drain();
    write_codes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    random_frames(10);

    drain();
    quiet = 1'b1;
    write_codes('{FC_READ, FC_SWRITE, FC_SCOIL, FC_MWRITE, FC_MCOIL});
    random_frames(35);

    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("[modbus_rtu_request_framer_top] OK");
    else
      $display("[modbus_rtu_request_framer_top] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[modbus_rtu_request_framer_top] ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/mrf_pkg.sv
design/mrf_front.sv
design/mrf_back.sv
design/modbus_rtu_request_framer_top.sv
tb/tb_modbus_rtu_request_framer_top.sv
